/* hdl/eod_pkg.sv */
// Shared types, step codes and calendar helpers for the Easter offset date core.
// No dependencies; imported by the controller, the datapath and the top level.
package eod_pkg;

  typedef logic [2:0] step_t;

  // Datapath step codes, issued one per cycle by the controller.
  localparam step_t STEP_NONE = 3'd0;
  localparam step_t STEP_CENT = 3'd1;  // century and year within century
  localparam step_t STEP_GOLD = 3'd2;  // golden number, century split, f, leap flag
  localparam step_t STEP_GCOR = 3'd3;  // g, c/4 and c%4
  localparam step_t STEP_EPCT = 3'd4;  // h (epact term)
  localparam step_t STEP_WDAY = 3'd5;  // l (weekday term)
  localparam step_t STEP_BASE = 3'd6;  // m and computus base
  localparam step_t STEP_ORD  = 3'd7;  // day of year plus offset, clamped
  localparam step_t STEP_LAST = STEP_ORD;

  typedef struct packed {
    logic  load;      // capture the input beat
    step_t step;      // computus step to perform
    logic  walk;      // advance the month walk by one month
    logic  out_load;  // move the finished date into the output register
  } eod_cmd_t;

  typedef struct packed {
    logic walk_done;  // day now falls inside the current month, or the month is December
  } eod_stat_t;

  // Month lengths in the Gregorian calendar.
  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mon);
    logic [4:0] len;
    case (mon)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4,
      4'd6,
      4'd9,
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

/* hdl/easter_offset_date_core.sv */
// Easter offset date core: Gregorian Easter plus a signed day offset, as month and day.
// A beat is taken only when idle; the core then runs the seven computus steps and the
// month walk, which steps one month per cycle, and takes no new beat until the result
// is loaded into the output register, which waits while an earlier result is not taken.
// Reset (rst, synchronous, active high) clears the sequencer and out_valid only.
// Depends on eod_pkg, eod_ctrl and eod_dpath.
module easter_offset_date_core import eod_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic        [13:0] year,
  input  logic signed [6:0]  day_offset,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [3:0]  month,
  output logic        [4:0]  day
);

  // Command and status bundles between the sequencer and the datapath.
  eod_cmd_t  cmd;
  eod_stat_t stat;

  // Sequencer: accept a beat when idle, run the computus steps, walk the
  // months, then hold the result in the output register until taken. A new
  // beat may be accepted while the previous result still waits.
  eod_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: computus terms by reciprocal multiplies, day-of-year with the
  // offset, and the month walk that turns it back into month and day.
  eod_dpath u_dpath (
    .clk        (clk),
    .cmd        (cmd),
    .stat       (stat),
    .year       (year),
    .day_offset (day_offset),
    .month      (month),
    .day        (day)
  );

endmodule

/* hdl/eod_ctrl.sv */
// Sequencer for the Easter offset date core: handshakes and step commands.
// Depends on eod_pkg.
module eod_ctrl import eod_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  eod_stat_t stat,
  output eod_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  step_t      step;
  step_t      step_next;
  logic       out_valid_next;
  logic       can_load;

  assign in_ready = (state == ST_IDLE);
  assign can_load = !out_valid || out_ready;

  always_comb begin
    state_next   = state;
    step_next    = step;
    cmd.load     = 1'b0;
    cmd.step     = STEP_NONE;
    cmd.walk     = 1'b0;
    cmd.out_load = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CALC;
          step_next  = STEP_CENT;
        end
      end
      ST_CALC: begin
        cmd.step = step;
        if (step == STEP_LAST) begin
          state_next = ST_WALK;
        end else begin
          step_next = step + step_t'(1);
        end
      end
      ST_WALK: begin
        if (!stat.walk_done) begin
          cmd.walk = 1'b1;
        end else if (can_load) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= STEP_NONE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* hdl/eod_dpath.sv */
// Datapath for the Easter offset date core: computus terms and month walk.
// Depends on eod_pkg; driven by commands from eod_ctrl.
module eod_dpath import eod_pkg::*; (
  input  logic               clk,
  input  eod_cmd_t           cmd,
  output eod_stat_t          stat,
  input  logic        [13:0] year,
  input  logic signed [6:0]  day_offset,
  output logic        [3:0]  month,
  output logic        [4:0]  day
);

  logic        [13:0] yr;
  logic signed [6:0]  off;
  logic [7:0] b;
  logic [6:0] c;
  logic [4:0] a;
  logic [5:0] d;
  logic [1:0] e;
  logic [2:0] f;
  logic [5:0] g;
  logic [4:0] i;
  logic [1:0] k;
  logic [4:0] h;
  logic [2:0] l;
  logic [7:0] base;
  logic       leap;
  logic [8:0] ord;
  logic [3:0] mon;

  // Divisions by constants use reciprocal multiplies, exact over the value ranges.
  logic [26:0] p100;
  logic [7:0]  b_w;
  logic [6:0]  c_w;
  assign p100 = 27'(yr) * 27'd5243;
  assign b_w  = p100[26:19];
  assign c_w  = 7'(yr - 14'(b_w) * 14'd100);

  logic [29:0] p19;
  logic [9:0]  q19;
  logic [4:0]  a_w;
  assign p19 = 30'(yr) * 30'd55189;
  assign q19 = p19[29:20];
  assign a_w = 5'(yr - 14'(q19) * 14'd19);

  logic [8:0]  bf;
  logic [15:0] pf;
  assign bf = 9'(b) + 9'd8;
  assign pf = 16'(bf) * 16'd41;

  logic [8:0]  bg;
  logic [15:0] pg;
  assign bg = 9'(b) - 9'(f) + 9'd1;
  assign pg = 16'(bg) * 16'd171;

  logic [9:0]  hx;
  logic [19:0] ph;
  logic [4:0]  hq;
  logic [4:0]  h_w;
  assign hx  = 10'(a) * 10'd19 + 10'(b) - 10'(d) - 10'(g) + 10'd15;
  assign ph  = 20'(hx) * 20'd547;
  assign hq  = ph[18:14];
  assign h_w = 5'(hx - 10'(hq) * 10'd30);

  logic [6:0]  lx;
  logic [13:0] pl;
  logic [3:0]  lq;
  logic [2:0]  l_w;
  assign lx  = 7'd32 + 7'({e, 1'b0}) + 7'({i, 1'b0}) - 7'(h) - 7'(k);
  assign pl  = 14'(lx) * 14'd147;
  assign lq  = pl[13:10];
  assign l_w = 3'(lx - 7'(lq) * 7'd7);

  logic [8:0] mx;
  logic [7:0] base_w;
  assign mx     = 9'(a) + 9'(h) * 9'd11 + 9'(l) * 9'd22;
  assign base_w = 8'(h) + 8'(l) + 8'd114 - ((mx >= 9'd451) ? 8'd7 : 8'd0);

  // Easter falls in March or April; fold in the months before it and the offset.
  logic               em4;
  logic [4:0]         ed;
  logic [8:0]         pre;
  logic [8:0]         total;
  logic signed [10:0] ord_raw;
  logic [8:0]         ord_w;
  assign em4     = (base >= 8'd124);
  assign ed      = em4 ? 5'(base - 8'd123) : 5'(base - 8'd92);
  assign pre     = (em4 ? 9'd90 : 9'd59) + 9'(leap);
  assign total   = 9'd365 + 9'(leap);
  assign ord_raw = $signed({2'b00, pre}) + $signed({6'b000000, ed}) + 11'(off);

  always_comb begin
    if (ord_raw < 11'sd1) begin
      ord_w = 9'd1;
    end else if (ord_raw > $signed({2'b00, total})) begin
      ord_w = total;
    end else begin
      ord_w = ord_raw[8:0];
    end
  end

  logic [4:0] len;
  assign len            = month_len(leap, mon);
  assign stat.walk_done = !((ord > 9'(len)) && (mon < 4'd12));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      yr  <= year;
      off <= day_offset;
    end
    case (cmd.step)
      STEP_CENT: begin
        b <= b_w;
        c <= c_w;
      end
      STEP_GOLD: begin
        a    <= a_w;
        d    <= b[7:2];
        e    <= b[1:0];
        f    <= pf[12:10];
        leap <= (yr[1:0] == 2'd0) && ((c != 7'd0) || (b[1:0] == 2'd0));
      end
      STEP_GCOR: begin
        g <= pg[14:9];
        i <= c[6:2];
        k <= c[1:0];
      end
      STEP_EPCT: begin
        h <= h_w;
      end
      STEP_WDAY: begin
        l <= l_w;
      end
      STEP_BASE: begin
        base <= base_w;
      end
      STEP_ORD: begin
        ord <= ord_w;
        mon <= 4'd1;
      end
      default: begin
      end
    endcase
    if (cmd.walk) begin
      ord <= ord - 9'(len);
      mon <= mon + 4'd1;
    end
    if (cmd.out_load) begin
      month <= mon;
      day   <= ord[4:0];
    end
  end

endmodule
